### rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
// define ASSERT_OFF to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property on clk_i, disabled while rst_ni is low
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property on an explicit clock and active-low reset
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg)

`endif

`endif

### rtl/core/plle_pkg.sv
`timescale 1ns / 1ps

package plle_pkg;

  // stream field widths and packing
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned CMD_LSB     = 0;
  localparam int unsigned POS_LSB     = CMD_LSB + CMD_W;
  localparam int unsigned VAL_LSB     = POS_LSB + POS_W;
  localparam int unsigned IN_TDATA_W  = 48;

  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned FOUND_W     = 6;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned FREE_W      = 7;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - STATUS_W - FOUND_W - LEN_W - FREE_W;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } plle_op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } plle_status_e;

  // node memory read address select
  typedef enum logic [1:0] {
    RD_NONE,
    RD_FREE,
    RD_HEAD,
    RD_NEXT
  } plle_rd_e;

  // link memory write operation
  typedef enum logic [2:0] {
    LW_NONE,
    LW_INIT,
    LW_NEW_HEAD,
    LW_NEW_NEXT,
    LW_PREV_NEW,
    LW_UNLINK,
    LW_FREE
  } plle_lwr_e;

  // controller states
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_TAKE,
    S_HEAD,
    S_WALK,
    S_LINK,
    S_FREE,
    S_DONE
  } plle_state_e;

  // controller to datapath
  typedef struct packed {
    logic         load_item;
    plle_rd_e     rd_sel;
    logic         alloc;
    plle_lwr_e    link_wr;
    logic         res_load;
    plle_status_e res_status;
    logic         res_found;
  } plle_cmd_t;

  // datapath to controller
  typedef struct packed {
    plle_op_e op;
    logic     pool_empty;
    logic     list_empty;
    logic     pos_zero;
    logic     ins_bad;
    logic     rm_bad;
    logic     at_ins_target;
    logic     at_rm_target;
    logic     at_tail;
    logic     val_match;
    logic     init_last;
    logic     out_busy;
  } plle_stat_t;

endpackage

### rtl/core/positional_linked_list_engine.sv
`timescale 1ns / 1ps

// Singly linked list of DATA_WIDTH-bit values kept in a pool of CAPACITY nodes,
// with freed nodes kept on a free list. Each input transfer carries one command
// (insert at a position, remove at a position, search for a value) and yields
// exactly one result transfer with status, found position, list length and free
// count. One command is worked at a time. The walk reads one list node per cycle
// from the link memory. A finished result waits until the output register has
// room, and no new command is taken meanwhile. After reset the link memory is
// swept once to build the initial free list; no input is taken during the sweep.
module positional_linked_list_engine
  import plle_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // command [1:0], position [9:2], value [41:10], zero fill above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // status [2:0], found_position [8:3], list_length [15:9], free_count [22:16]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  plle_cmd_t  cmd;
  plle_stat_t stat;

  plle_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  plle_datapath #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata_i),
    .out_ready_i(m_axis_tready_i),
    .out_valid_o(m_axis_tvalid_o),
    .out_data_o (m_axis_tdata_o),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

### rtl/core/plle_ram.sv
`timescale 1ns / 1ps

module plle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/plle_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plle_ctrl
  import plle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  plle_stat_t stat_i,
  output plle_cmd_t  cmd_o
);

  plle_state_e  state_q, state_d;
  plle_status_e status_q, status_d;
  logic         found_q, found_d;

  // state and result code registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      status_q <= ST_OK;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d          = state_q;
    status_d         = status_q;
    found_d          = found_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.rd_sel     = RD_NONE;
    cmd_o.link_wr    = LW_NONE;
    cmd_o.res_status = status_q;
    cmd_o.res_found  = found_q;

    unique case (state_q)
      S_INIT: begin
        cmd_o.link_wr = LW_INIT;
        if (stat_i.init_last) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DECODE;
        end
      end

      S_DECODE: begin
        found_d  = 1'b0;
        status_d = ST_OK;
        unique case (stat_i.op)
          OP_INSERT: begin
            priority if (stat_i.pool_empty) begin
              status_d = ST_EXHAUSTED;
              state_d  = S_DONE;
            end else if (!stat_i.pos_zero && !stat_i.list_empty && stat_i.ins_bad) begin
              status_d = ST_BAD_POS;
              state_d  = S_DONE;
            end else begin
              cmd_o.rd_sel = RD_FREE;
              state_d      = S_TAKE;
            end
          end
          OP_REMOVE: begin
            priority if (stat_i.list_empty) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else if (stat_i.rm_bad) begin
              status_d = ST_BAD_POS;
              state_d  = S_DONE;
            end else begin
              cmd_o.rd_sel = RD_HEAD;
              state_d      = S_WALK;
            end
          end
          OP_SEARCH: begin
            if (stat_i.list_empty) begin
              status_d = ST_NOT_FOUND;
              state_d  = S_DONE;
            end else begin
              cmd_o.rd_sel = RD_HEAD;
              state_d      = S_WALK;
            end
          end
          OP_NONE: begin
            status_d = ST_BAD_POS;
            state_d  = S_DONE;
          end
        endcase
      end

      // pop the free list; new node goes to the head or the walk starts
      S_TAKE: begin
        cmd_o.alloc = 1'b1;
        if (stat_i.pos_zero || stat_i.list_empty) begin
          state_d = S_HEAD;
        end else begin
          cmd_o.rd_sel = RD_HEAD;
          state_d      = S_WALK;
        end
      end

      S_HEAD: begin
        cmd_o.link_wr = LW_NEW_HEAD;
        state_d       = S_DONE;
      end

      // one list node per cycle
      S_WALK: begin
        unique case (stat_i.op)
          OP_INSERT: begin
            if (stat_i.at_ins_target) begin
              cmd_o.link_wr = LW_NEW_NEXT;
              state_d       = S_LINK;
            end else begin
              cmd_o.rd_sel = RD_NEXT;
            end
          end
          OP_REMOVE: begin
            if (stat_i.at_rm_target) begin
              cmd_o.link_wr = LW_UNLINK;
              state_d       = S_FREE;
            end else begin
              cmd_o.rd_sel = RD_NEXT;
            end
          end
          OP_SEARCH: begin
            priority if (stat_i.val_match) begin
              found_d = 1'b1;
              state_d = S_DONE;
            end else if (stat_i.at_tail) begin
              status_d = ST_NOT_FOUND;
              state_d  = S_DONE;
            end else begin
              cmd_o.rd_sel = RD_NEXT;
            end
          end
          OP_NONE: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_LINK: begin
        cmd_o.link_wr = LW_PREV_NEW;
        state_d       = S_DONE;
      end

      S_FREE: begin
        cmd_o.link_wr = LW_FREE;
        state_d       = S_DONE;
      end

      // hand the result to the output register once it has room
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `ASSERT_CLK(a_init_holds, (state_q == S_INIT) && !stat_i.init_last |=> (state_q == S_INIT), "clearing pass left early")
  `ASSERT_CLK(a_done_waits, (state_q == S_DONE) && stat_i.out_busy |=> (state_q == S_DONE), "result dropped while output stalled")
  `ASSERT_CLK(a_load_to_idle, cmd_o.res_load |=> (state_q == S_IDLE), "result load did not return to idle")

endmodule

### rtl/core/plle_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plle_datapath
  import plle_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  input  plle_cmd_t              cmd_i,
  output plle_stat_t             stat_o
);

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned LINK_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = ((LINK_W > POS_W) ? LINK_W : POS_W) + 1;
  localparam logic [LINK_W-1:0] NIL     = LINK_W'(CAPACITY);
  localparam logic [LINK_W:0]   CAP_SUM = (LINK_W + 1)'(CAPACITY);

  // captured item
  plle_op_e              op_q;
  logic [POS_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] val_q;

  // list and pool bookkeeping
  logic [LINK_W-1:0] head_q, free_head_q, len_q, free_q;
  logic [IDX_W-1:0]  init_q;

  // walk pointers
  logic [IDX_W-1:0] cur_q, prev_q, new_q, n_q;

  // output register
  logic                 out_valid_q;
  plle_status_e         out_status_q;
  logic [FOUND_W-1:0]   out_found_q;
  logic [LEN_W-1:0]     out_len_q;
  logic [FREE_W-1:0]    out_free_q;

  // memory ports
  logic                  link_we;
  logic [IDX_W-1:0]      link_waddr;
  logic [LINK_W-1:0]     link_wdata;
  logic [LINK_W-1:0]     rd_link;
  logic [DATA_WIDTH-1:0] rd_value;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;

  logic [CMP_W-1:0] pos_ext, len_ext, n_ext;
  logic [LINK_W:0]  pool_sum;

  // read address select
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = cur_q;
    unique case (cmd_i.rd_sel)
      RD_NONE: rd_en   = 1'b0;
      RD_FREE: rd_addr = free_head_q[IDX_W-1:0];
      RD_HEAD: rd_addr = head_q[IDX_W-1:0];
      RD_NEXT: rd_addr = rd_link[IDX_W-1:0];
    endcase
  end

  // link write select
  always_comb begin
    link_we    = 1'b1;
    link_waddr = cur_q;
    link_wdata = rd_link;
    unique case (cmd_i.link_wr)
      LW_NONE: link_we = 1'b0;
      LW_INIT: begin
        link_waddr = init_q;
        link_wdata = LINK_W'(init_q) + LINK_W'(1);
      end
      LW_NEW_HEAD: begin
        link_waddr = new_q;
        link_wdata = head_q;
      end
      LW_NEW_NEXT: begin
        link_waddr = new_q;
      end
      LW_PREV_NEW: begin
        link_wdata = LINK_W'(new_q);
      end
      LW_UNLINK: begin
        // unlinking the head updates the head register instead
        link_we    = (n_q != '0);
        link_waddr = prev_q;
      end
      LW_FREE: begin
        link_wdata = free_head_q;
      end
      default: link_we = 1'b0;
    endcase
  end

  plle_ram #(
    .WIDTH(LINK_W),
    .DEPTH(CAPACITY)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_link)
  );

  plle_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.alloc),
    .waddr_i(free_head_q[IDX_W-1:0]),
    .wdata_i(val_q),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_value)
  );

  // bookkeeping registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= NIL;
      free_head_q <= '0;
      len_q       <= '0;
      free_q      <= NIL;
      init_q      <= '0;
    end else begin
      if (cmd_i.link_wr == LW_INIT) begin
        init_q <= init_q + IDX_W'(1);
      end
      if (cmd_i.alloc) begin
        free_head_q <= rd_link;
        free_q      <= free_q - LINK_W'(1);
      end
      unique case (cmd_i.link_wr)
        LW_NEW_HEAD: begin
          head_q <= LINK_W'(new_q);
          len_q  <= len_q + LINK_W'(1);
        end
        LW_PREV_NEW: begin
          len_q <= len_q + LINK_W'(1);
        end
        LW_UNLINK: begin
          if (n_q == '0) begin
            head_q <= rd_link;
          end
        end
        LW_FREE: begin
          free_head_q <= LINK_W'(cur_q);
          free_q      <= free_q + LINK_W'(1);
          len_q       <= len_q - LINK_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // item capture and walk pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q  <= plle_op_e'(in_data_i[CMD_LSB +: CMD_W]);
      pos_q <= in_data_i[POS_LSB +: POS_W];
      val_q <= DATA_WIDTH'(in_data_i[VAL_LSB +: VAL_W]);
    end
    if (cmd_i.alloc) begin
      new_q <= free_head_q[IDX_W-1:0];
    end
    unique case (cmd_i.rd_sel)
      RD_HEAD: begin
        cur_q <= head_q[IDX_W-1:0];
        n_q   <= '0;
      end
      RD_NEXT: begin
        prev_q <= cur_q;
        cur_q  <= rd_link[IDX_W-1:0];
        n_q    <= n_q + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  // output register, refilled as soon as its transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_status_q <= cmd_i.res_status;
      out_found_q  <= cmd_i.res_found ? FOUND_W'(n_q) : '0;
      out_len_q    <= LEN_W'(len_q);
      out_free_q   <= FREE_W'(free_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{OUT_PAD_W{1'b0}}, out_free_q, out_len_q, out_found_q, out_status_q};

  // status toward the controller
  assign pos_ext  = CMP_W'(pos_q);
  assign len_ext  = CMP_W'(len_q);
  assign n_ext    = CMP_W'(n_q);
  assign pool_sum = (LINK_W + 1)'(free_q) + (LINK_W + 1)'(len_q);

  always_comb begin
    stat_o.op            = op_q;
    stat_o.pool_empty    = (free_q == '0);
    stat_o.list_empty    = (head_q == NIL);
    stat_o.pos_zero      = (pos_q == '0);
    stat_o.ins_bad       = (pos_ext > len_ext);
    stat_o.rm_bad        = (pos_ext >= len_ext);
    stat_o.at_ins_target = ((n_ext + CMP_W'(1)) == pos_ext);
    stat_o.at_rm_target  = (n_ext == pos_ext);
    stat_o.at_tail       = ((n_ext + CMP_W'(1)) == len_ext);
    stat_o.val_match     = (rd_value == val_q);
    stat_o.init_last     = (init_q == IDX_W'(CAPACITY - 1));
    stat_o.out_busy      = out_valid_q && !out_ready_i;
  end

  `ASSERT_CLK(a_pool_balance, cmd_i.res_load |-> (pool_sum == CAP_SUM), "free and list counts do not add up to the pool")
  `ASSERT_CLK(a_head_len, cmd_i.res_load |-> ((head_q == NIL) == (len_q == '0)), "head marker and length disagree")
  `ASSERT_CLK_RST(a_no_overwrite, clk_i, rst_ni, cmd_i.res_load |-> !(out_valid_q && !out_ready_i), "result loaded over a stalled one")

endmodule

### verif/positional_linked_list_engine_test.sv
`timescale 1ns / 1ps

module positional_linked_list_engine_test;
  import plle_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned NIL_NODE    = CAPACITY;
  localparam int unsigned FOUND_LSB   = STATUS_W;
  localparam int unsigned LEN_LSB     = FOUND_LSB + FOUND_W;
  localparam int unsigned FREE_LSB    = LEN_LSB + LEN_W;
  localparam int unsigned ITEM_TARGET = 550;
  localparam int unsigned STEADY_FROM = 460;
  localparam int unsigned SETTLE      = 100;
  localparam int unsigned CYCLE_LIMIT = 500000;

  // one expected result transfer
  typedef struct {
    plle_status_e      status;
    logic [FOUND_W-1:0] found;
    logic [LEN_W-1:0]   length;
    logic [FREE_W-1:0]  free;
  } list_result_t;

  typedef enum {PH_GROW, PH_SHRINK, PH_MIX, PH_FILL, PH_EMPTY} phase_e;

  // shadow copy of the node pool, predicts each result in command order
  class list_result_checker;
    logic [VAL_W-1:0] node_value [CAPACITY];
    int unsigned      node_link [CAPACITY];
    int unsigned      head_node;
    int unsigned      free_top;
    int unsigned      list_len;
    int unsigned      free_left;
    list_result_t     expected_results [$];
    int unsigned      mismatch_count;

    function new();
      for (int unsigned i = 0; i < CAPACITY; i++) begin
        node_link[i]  = i + 1;
        node_value[i] = '0;
      end
      head_node      = NIL_NODE;
      free_top       = 0;
      list_len       = 0;
      free_left      = CAPACITY;
      mismatch_count = 0;
    endfunction

    // follow steps links from the head, nil marker if the list runs out
    function int unsigned walk_links(int unsigned steps);
      int unsigned p;
      int unsigned n;
      p = head_node;
      n = 0;
      while (p < CAPACITY && n < steps) begin
        p = node_link[p];
        n++;
      end
      return p;
    endfunction

    // freed nodes go to the front of the free list
    function void release_node(int unsigned idx);
      node_link[idx] = free_top;
      free_top       = idx;
      free_left++;
    endfunction

    function plle_status_e insert_at(int unsigned pos, logic [VAL_W-1:0] val);
      int unsigned idx;
      int unsigned prev;
      if (free_left == 0) return ST_EXHAUSTED;
      idx       = free_top;
      free_top  = node_link[idx];
      free_left--;
      node_value[idx] = val;
      // empty list or position zero: new head
      if (pos == 0 || head_node == NIL_NODE) begin
        node_link[idx] = head_node;
        head_node      = idx;
        list_len++;
        return ST_OK;
      end
      prev = walk_links(pos - 1);
      if (prev == NIL_NODE) begin
        release_node(idx);
        return ST_BAD_POS;
      end
      node_link[idx]  = node_link[prev];
      node_link[prev] = idx;
      list_len++;
      return ST_OK;
    endfunction

    function plle_status_e remove_at(int unsigned pos);
      int unsigned prev;
      int unsigned cur;
      if (head_node == NIL_NODE) return ST_EMPTY;
      if (pos == 0) begin
        cur       = head_node;
        head_node = node_link[cur];
        release_node(cur);
        list_len--;
        return ST_OK;
      end
      prev = walk_links(pos - 1);
      if (prev == NIL_NODE) return ST_BAD_POS;
      cur = node_link[prev];
      if (cur == NIL_NODE) return ST_BAD_POS;
      node_link[prev] = node_link[cur];
      release_node(cur);
      list_len--;
      return ST_OK;
    endfunction

    function plle_status_e search_for(logic [VAL_W-1:0] val, output int unsigned where);
      int unsigned p;
      int unsigned n;
      p     = head_node;
      n     = 0;
      where = 0;
      while (p < CAPACITY && n < CAPACITY) begin
        if (node_value[p] == val) begin
          where = n;
          return ST_OK;
        end
        p = node_link[p];
        n++;
      end
      return ST_NOT_FOUND;
    endfunction

    // value held at a list position, only asked for positions on the list
    function logic [VAL_W-1:0] value_at(int unsigned pos);
      return node_value[walk_links(pos)];
    endfunction

    // accepted command transfer
    function void note_command(plle_op_e op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
      list_result_t r;
      int unsigned  where;
      where = 0;
      case (op)
        OP_INSERT: r.status = insert_at(pos, val);
        OP_REMOVE: r.status = remove_at(pos);
        OP_SEARCH: r.status = search_for(val, where);
        default:   r.status = ST_BAD_POS;
      endcase
      r.found  = where[FOUND_W-1:0];
      r.length = list_len[LEN_W-1:0];
      r.free   = free_left[FREE_W-1:0];
      expected_results.push_back(r);
    endfunction

    // accepted result transfer against the oldest prediction
    function void check_result(logic [OUT_TDATA_W-1:0] word);
      list_result_t e;
      logic [STATUS_W-1:0] st;
      logic [FOUND_W-1:0]  fp;
      logic [LEN_W-1:0]    ln;
      logic [FREE_W-1:0]   fr;
      st = word[0 +: STATUS_W];
      fp = word[FOUND_LSB +: FOUND_W];
      ln = word[LEN_LSB +: LEN_W];
      fr = word[FREE_LSB +: FREE_W];
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: status %0d length %0d free %0d", st, ln, fr);
        mismatch_count++;
        return;
      end
      e = expected_results.pop_front();
      if (st !== e.status) begin
        $error("status mismatch: expected %0d, actual %0d", e.status, st);
        mismatch_count++;
      end
      if (fp !== e.found) begin
        $error("found_position mismatch: expected %0d, actual %0d", e.found, fp);
        mismatch_count++;
      end
      if (ln !== e.length) begin
        $error("list_length mismatch: expected %0d, actual %0d", e.length, ln);
        mismatch_count++;
      end
      if (fr !== e.free) begin
        $error("free_count mismatch: expected %0d, actual %0d", e.free, fr);
        mismatch_count++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // command [1:0], position [9:2], value [41:10], zero fill above
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // status [2:0], found_position [8:3], list_length [15:9], free_count [22:16]
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  list_result_checker sb;
  int unsigned        commands_sent = 0;
  int unsigned        cycle_count = 0;
  bit                 sender_gaps = 1'b0;
  bit                 steady_phase = 1'b0;

  positional_linked_list_engine i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result transfers
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o === 1'b1 && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  // receiver stalls in bursts, none in the steady tail
  initial begin
    forever begin
      if (steady_phase || $urandom_range(0, 2) != 0) begin
        m_axis_tready_i <= 1'b1;
        repeat (steady_phase ? 1 : $urandom_range(1, 30)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // one command transfer, with an optional idle burst in front
  task automatic send_command(plle_op_e op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[CMD_LSB +: CMD_W] = op;
    word[POS_LSB +: POS_W] = pos;
    word[VAL_LSB +: VAL_W] = val;
    if (sender_gaps && !steady_phase && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_command(op, pos, val);
    commands_sent++;
  endtask

  // hold off the sender until every pending result is back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_results.size() != 0) @(posedge clk_i);
  endtask

  // random command shaped by the current phase
  task automatic issue_random(phase_e ph);
    int unsigned      r;
    int unsigned      len;
    plle_op_e         op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    len = sb.list_len;
    r   = $urandom_range(0, 99);
    case (ph)
      PH_GROW:   op = r < 65 ? OP_INSERT : r < 80 ? OP_REMOVE : r < 97 ? OP_SEARCH : OP_NONE;
      PH_SHRINK: op = r < 20 ? OP_INSERT : r < 80 ? OP_REMOVE : r < 97 ? OP_SEARCH : OP_NONE;
      default:   op = r < 35 ? OP_INSERT : r < 65 ? OP_REMOVE : r < 97 ? OP_SEARCH : OP_NONE;
    endcase
    // mostly reachable positions, some at the end and some anywhere
    r = $urandom_range(0, 9);
    if (r == 0) pos = POS_W'($urandom_range(0, 255));
    else if (r == 1) pos = POS_W'(len);
    else if (op == OP_REMOVE && len > 0) pos = POS_W'($urandom_range(0, len - 1));
    else pos = POS_W'($urandom_range(0, len));
    // searches mostly hit, small values make duplicates
    if (op == OP_SEARCH && len > 0 && $urandom_range(0, 4) < 3)
      val = sb.value_at($urandom_range(0, len - 1));
    else if ($urandom_range(0, 3) == 0) val = VAL_W'($urandom_range(0, 7));
    else val = $urandom;
    send_command(op, pos, val);
  endtask

  // fill the pool, then knock on it while exhausted and search the full list
  task automatic fill_pool();
    while (sb.free_left != 0) send_command(OP_INSERT, POS_W'($urandom_range(0, sb.list_len)), $urandom);
    send_command(OP_INSERT, 8'd0, $urandom);
    send_command(OP_INSERT, 8'd255, $urandom);
    send_command(OP_INSERT, POS_W'($urandom_range(0, 255)), $urandom);
    send_command(OP_SEARCH, 8'd0, sb.value_at(sb.list_len - 1));
    send_command(OP_SEARCH, 8'd0, $urandom);
  endtask

  // remove until empty, then once more on the empty list
  task automatic empty_list();
    while (sb.list_len != 0) send_command(OP_REMOVE, POS_W'($urandom_range(0, sb.list_len - 1)), $urandom);
    send_command(OP_REMOVE, POS_W'($urandom_range(0, 255)), $urandom);
  endtask

  initial begin
    phase_e      ph;
    int unsigned count;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list cases
    send_command(OP_SEARCH, 8'd0, 32'h0000_0000);
    send_command(OP_REMOVE, 8'd0, 32'h0000_0000);
    send_command(OP_REMOVE, 8'd255, 32'hFFFF_FFFF);
    // insert into an empty list goes to the head whatever the position
    send_command(OP_INSERT, 8'd200, 32'hFFFF_FFFF);
    send_command(OP_INSERT, 8'd0, 32'h0000_0000);
    send_command(OP_INSERT, 8'd2, 32'hA5A5_A5A5);
    // insert past the end hands its node back
    send_command(OP_INSERT, 8'd5, 32'h1111_1111);
    send_command(OP_INSERT, 8'd255, 32'h2222_2222);
    send_command(OP_INSERT, 8'd1, 32'h5A5A_5A5A);
    send_command(OP_SEARCH, 8'd0, 32'hFFFF_FFFF);
    send_command(OP_SEARCH, 8'd255, 32'h0000_0000);
    send_command(OP_SEARCH, 8'd0, 32'h1111_1111);
    // unused command
    send_command(OP_NONE, 8'd255, 32'hFFFF_FFFF);
    send_command(OP_NONE, 8'd0, 32'h0000_0000);
    // remove past the end, then tail, middle, head
    send_command(OP_REMOVE, 8'd4, 32'h0000_0000);
    send_command(OP_REMOVE, 8'd255, 32'h0000_0000);
    send_command(OP_REMOVE, 8'd3, 32'h0000_0000);
    send_command(OP_REMOVE, 8'd1, 32'h0000_0000);
    send_command(OP_REMOVE, 8'd0, 32'h0000_0000);
    // duplicate value: search returns the first match
    send_command(OP_INSERT, 8'd1, 32'hFFFF_FFFF);
    send_command(OP_INSERT, 8'd0, 32'h0000_0007);
    send_command(OP_SEARCH, 8'd0, 32'hFFFF_FFFF);
    drain_results();

    // pool exhaustion and full teardown once for sure
    sender_gaps = 1'b1;
    fill_pool();
    empty_list();
    drain_results();

    // random phases
    while (commands_sent < ITEM_TARGET) begin
      ph          = phase_e'($urandom_range(0, 4));
      sender_gaps = $urandom_range(0, 1);
      if (commands_sent >= STEADY_FROM) steady_phase = 1'b1;
      case (ph)
        PH_FILL:  fill_pool();
        PH_EMPTY: empty_list();
        default: begin
          count = $urandom_range(20, 50);
          repeat (count) issue_random(ph);
        end
      endcase
      if (!steady_phase && $urandom_range(0, 1) == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/plle_pkg.sv
rtl/core/plle_ram.sv
rtl/core/plle_ctrl.sv
rtl/core/plle_datapath.sv
rtl/core/positional_linked_list_engine.sv
verif/positional_linked_list_engine_test.sv
